[src/nmea_gll_position_parser_assert.svh]
// Assertion helpers for the GLL position parser.
// Building with SYNTH defined leaves the checks out.
`ifndef NMEA_GLL_POSITION_PARSER_ASSERT_SVH
`define NMEA_GLL_POSITION_PARSER_ASSERT_SVH

`ifndef SYNTH

// expr must hold at every clock edge outside reset
`define NGP_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("nmea gll parser: invariant violated");

// cons must hold in the cycle after ante
`define NGP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nmea gll parser: sequence check failed");

`else

`define NGP_ASSERT_ALWAYS(label, clk, rst, expr)
`define NGP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/ngp_pkg.sv]
package ngp_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // sentence positions
   localparam logic [5:0] POS_HDR_END  = 6'd5;
   localparam logic [5:0] POS_COMMA    = 6'd6;
   localparam logic [5:0] POS_LAT_DEG  = 6'd7;
   localparam logic [5:0] POS_LAT_MIN  = 6'd9;
   localparam logic [5:0] POS_LAT_PT   = 6'd11;
   localparam logic [5:0] POS_LAT_EMIT = 6'd17;
   localparam logic [5:0] POS_AFTER_LAT = 6'd18;
   localparam logic [5:0] POS_LON_DEG  = 6'd20;
   localparam logic [5:0] POS_LON_MIN  = 6'd23;
   localparam logic [5:0] POS_LON_PT   = 6'd25;
   localparam logic [5:0] POS_LON_EMIT = 6'd31;
   localparam logic [5:0] POS_IDLE     = 6'd63;

   localparam int         DEG_W  = 10;
   localparam int         MIN_W  = 24;
   localparam int         COORD_W = 34;
   localparam int         FRAC_W = 25;
   localparam logic [COORD_W-1:0] DEG_SCALE = 34'd10000000;
   // floor(x / 3) = (x * RECIP3) >> 33 for any x below 2**32
   localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
   localparam int          RECIP3_SHIFT = 33;
   // largest fraction: floor((2**24 - 1) * 5 / 3)
   localparam logic [FRAC_W-1:0] FRAC_MAX = 25'd27962025;

   typedef struct packed {
      logic                   is_lon;
      logic [DEG_W-1:0]       deg;
      logic [MIN_W-1:0]       minute;
   } coord_req_type;

   function automatic logic [7:0] hdr_letter(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h47; // G
         3'd1:    ch = 8'h4E; // N
         3'd2:    ch = 8'h47; // G
         3'd3:    ch = 8'h4C; // L
         default: ch = 8'h4C; // L
      endcase
      return ch;
   endfunction

endpackage

[src/nmea_gll_position_parser.sv]
// GLL position sentence parser. Feed the received character stream one byte
// per word on req_; a '$' restarts the sentence at any point. When the header
// reads "$GNGLL", the latitude and then the longitude magnitude come out on
// rsp_ as one word each, in units of 1e-7 degree (deg*1e7 + floor(min*5/3),
// minutes counted in 1e-5); rsp_tuser is 0 for latitude and 1 for longitude,
// hemisphere letters are ignored. Input bytes are taken one per clock,
// indefinitely, as long as results are drained. A result is offered on rsp_
// after the byte that follows its minute field is taken: that byte sits in
// the input register, the scaled values are captured in the product register
// and their sum in the result register. Throughput is set by the parser
// update on the input register; the degree and minute scaling multiplies sit
// in a stage of their own and add latency only.
module nmea_gll_position_parser (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // coordinate out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [33:0] degrees_e7, [39:34] zero
   output logic [0:0]  rsp_tuser    // [0] is_longitude
);
   import ngp_pkg::*;

   // parser -> scaling handoff: one word per finished coordinate
   logic          emit_valid;
   logic          emit_ready;
   coord_req_type emit_data;

   // character position tracking, header match and digit accumulation
   ngp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_data  (emit_data)
   );

   // scaling to 1e-7 degree, with its own output register
   ngp_coord u_coord (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_data  (emit_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[src/ngp_parser.sv]
`include "nmea_gll_position_parser_assert.svh"

module ngp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  emit_valid,
   input  logic                  emit_ready,
   output ngp_pkg::coord_req_type emit_data
);
   import ngp_pkg::*;

   logic             a_valid_ff, a_valid_in;
   logic [7:0]       a_byte_ff;
   logic             a_go;

   logic [5:0]       pos_ff, pos_in;
   logic             hm_ff, hm_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic [MIN_W-1:0] min_ff, min_in;
   logic             end_ff, end_in;
   logic             emit_lon;

   logic [5:0]       pe;
   logic [DEG_W-1:0] deg_b;
   logic [MIN_W-1:0] min_b;
   logic             end_b;
   logic             is_digit;
   logic [3:0]       digit;
   logic             in_deg, in_min, at_point;

   assign is_digit = (a_byte_ff >= CHAR_ZERO) && (a_byte_ff <= CHAR_NINE);
   assign digit    = a_byte_ff[3:0];

   always_comb begin
      pos_in     = pos_ff;
      hm_in      = hm_ff;
      deg_in     = deg_ff;
      min_in     = min_ff;
      end_in     = end_ff;
      emit_valid = 1'b0;
      emit_lon   = 1'b0;

      // the first latitude digit arrives while still at the comma slot
      pe = (pos_ff == POS_COMMA) ? POS_LAT_DEG : pos_ff;

      deg_b = deg_ff;
      min_b = min_ff;
      end_b = end_ff;
      if (pe == POS_LAT_DEG || pe == POS_LON_DEG) begin
         deg_b = '0;
         end_b = 1'b0;
      end
      if (pe == POS_LAT_MIN || pe == POS_LON_MIN) begin
         min_b = '0;
         end_b = 1'b0;
      end
      in_deg   = (pe >= POS_LAT_DEG && pe < POS_LAT_MIN) ||
                 (pe >= POS_LON_DEG && pe < POS_LON_MIN);
      in_min   = (pe >= POS_LAT_MIN && pe < POS_LAT_EMIT) ||
                 (pe >= POS_LON_MIN && pe < POS_LON_EMIT);
      at_point = (pe == POS_LAT_PT) || (pe == POS_LON_PT);

      if (a_valid_ff) begin
         if (a_byte_ff == CHAR_DOLLAR) begin
            pos_in = '0;
            hm_in  = 1'b1;
         end else if (pos_ff < POS_HDR_END) begin
            if (a_byte_ff != hdr_letter(pos_ff[2:0])) begin
               hm_in = 1'b0;
            end
            pos_in = pos_ff + 6'd1;
         end else if (pos_ff == POS_HDR_END) begin
            pos_in = POS_COMMA;
         end else begin
            pos_in = pe;
            if (pe <= POS_LON_EMIT && hm_ff) begin
               if (pe == POS_LAT_EMIT) begin
                  emit_valid = 1'b1;
                  pos_in     = POS_AFTER_LAT;
               end else if (pe == POS_LON_EMIT) begin
                  emit_valid = 1'b1;
                  emit_lon   = 1'b1;
                  pos_in     = POS_IDLE;
               end else begin
                  pos_in = pe + 6'd1;
                  if (in_deg) begin
                     end_in = end_b;
                     deg_in = deg_b;
                     if (!end_b && is_digit) begin
                        deg_in = (deg_b * 10'd10) + {6'd0, digit};
                     end else begin
                        end_in = 1'b1;
                     end
                  end else if (in_min) begin
                     end_in = end_b;
                     min_in = min_b;
                     if (at_point) begin
                        if (a_byte_ff != CHAR_POINT) begin
                           end_in = 1'b1;
                        end
                     end else if (!end_b && is_digit) begin
                        min_in = (min_b * 24'd10) + {20'd0, digit};
                     end else begin
                        end_in = 1'b1;
                        min_in = min_b * 24'd10;
                     end
                  end
               end
            end
         end
      end
   end

   assign a_go       = a_valid_ff && (!emit_valid || emit_ready);
   assign req_tready = !a_valid_ff || a_go;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_tvalid && req_tready) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         pos_ff     <= POS_IDLE;
         hm_ff      <= 1'b0;
         deg_ff     <= '0;
         min_ff     <= '0;
         end_ff     <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (a_go) begin
            pos_ff <= pos_in;
            hm_ff  <= hm_in;
            deg_ff <= deg_in;
            min_ff <= min_in;
            end_ff <= end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_byte_ff <= req_tdata;
      end
   end

   assign emit_data.is_lon = emit_lon;
   assign emit_data.deg    = deg_ff;
   assign emit_data.minute = min_ff;

   `NGP_ASSERT_ALWAYS(a_pos_range, clock, reset, (pos_ff <= POS_LON_EMIT) || (pos_ff == POS_IDLE))
   `NGP_ASSERT_ALWAYS(a_emit_needs_header, clock, reset, !emit_valid || hm_ff)
   `NGP_ASSERT_NEXT(a_lon_goes_idle, clock, reset, a_go && emit_valid && emit_lon, pos_ff == POS_IDLE)

endmodule

[src/ngp_coord.sv]
`include "nmea_gll_position_parser_assert.svh"

module ngp_coord (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   emit_valid,
   output logic                   emit_ready,
   input  ngp_pkg::coord_req_type emit_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // [33:0] degrees_e7, [39:34] zero
   output logic [0:0]             rsp_tuser    // [0] is_longitude
);
   import ngp_pkg::*;

   localparam int PROD_W = 27 + 32;

   // product stage
   logic               p_valid_ff, p_valid_in;
   logic               p_lon_ff;
   logic [COORD_W-1:0] p_deg_e7_ff, p_deg_e7_in;
   logic [FRAC_W-1:0]  p_frac_ff, p_frac_in;
   logic               p_go;
   logic [26:0]        min5;
   logic [PROD_W-1:0]  prod;

   // result stage
   logic               r_valid_ff, r_valid_in;
   logic               r_lon_ff;
   logic [COORD_W-1:0] r_coord_ff;

   assign min5        = {3'd0, emit_data.minute} * 27'd5;
   assign prod        = PROD_W'(min5) * PROD_W'(RECIP3);
   assign p_frac_in   = prod[RECIP3_SHIFT +: FRAC_W];
   assign p_deg_e7_in = COORD_W'(emit_data.deg) * DEG_SCALE;

   assign p_go       = p_valid_ff && (!r_valid_ff || rsp_tready);
   assign emit_ready = !p_valid_ff || p_go;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (emit_valid && emit_ready) begin
         p_valid_in = 1'b1;
      end else if (p_go) begin
         p_valid_in = 1'b0;
      end
      r_valid_in = r_valid_ff;
      if (p_go) begin
         r_valid_in = 1'b1;
      end else if (rsp_tready) begin
         r_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         p_lon_ff    <= emit_data.is_lon;
         p_deg_e7_ff <= p_deg_e7_in;
         p_frac_ff   <= p_frac_in;
      end
      if (p_go) begin
         r_lon_ff   <= p_lon_ff;
         r_coord_ff <= p_deg_e7_ff + COORD_W'(p_frac_ff);
      end
   end

   assign rsp_tvalid = r_valid_ff;
   assign rsp_tdata  = {6'd0, r_coord_ff};
   assign rsp_tuser  = r_lon_ff;

   `NGP_ASSERT_ALWAYS(a_frac_bound, clock, reset, !p_valid_ff || (p_frac_ff <= FRAC_MAX))
   `NGP_ASSERT_NEXT(a_prod_to_result, clock, reset, p_go, r_valid_ff)
   `NGP_ASSERT_NEXT(a_prod_holds, clock, reset, p_valid_ff && !p_go, p_valid_ff && $stable(p_deg_e7_ff) && $stable(p_frac_ff))

endmodule
